// File: hw/rtl/ppt_pkg.sv
// Shared types and constants for the point-in-polytope test block.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ROW_IDX_W   = 5;
    localparam int COUNT_W     = 6;
    localparam int M_TDATA_W   = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ppt_state_t;

    // per-cell control: load from the write request, or take the neighbor's row
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic issue;
    } eval_ctrl_t;

endpackage

// File: hw/rtl/ppt_cell.sv
// One storage cell of the plane ring: holds a row (normal x, y, z, offset).
// Depends on ppt_pkg.
`timescale 1ns / 1ps

module ppt_cell #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       aclk,
    input  ppt_pkg::cell_ctrl_t        ctrl,
    input  logic [4*COORD_WIDTH-1:0]   wr_row,
    input  logic [4*COORD_WIDTH-1:0]   nbr_row,
    output logic [4*COORD_WIDTH-1:0]   row
);
    import ppt_pkg::*;

    logic [4*COORD_WIDTH-1:0] row_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            row_reg <= wr_row;
        end else if (ctrl.shift) begin
            row_reg <= nbr_row;
        end
    end

    assign row = row_reg;

endmodule

// File: hw/rtl/ppt_eval.sv
// Plane evaluator: n.p + d against margin, one row per cycle, three stages.
// Products are split into half-width partials. Depends on ppt_pkg.
`timescale 1ns / 1ps

module ppt_eval #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ppt_pkg::eval_ctrl_t        ctrl,
    input  logic [4*COORD_WIDTH-1:0]   row,
    input  logic [3*COORD_WIDTH-1:0]   point,
    input  logic [COORD_WIDTH-1:0]     margin,
    output logic                       ok
);
    import ppt_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int LO_W = W / 2;
    localparam int HI_W = W - LO_W;
    localparam int PW   = 2 * W + 2;
    localparam int SW   = 2 * W + 3;

    // stage 1: partial products hh, hl, lh, ll per axis
    logic signed [PW-1:0] pp_next [3][4];
    logic signed [PW-1:0] pp_reg  [3][4];
    logic signed [W-1:0]  off1_reg;
    logic                 v1_reg;

    // stage 2: full products
    logic signed [SW-1:0] prod_next [3];
    logic signed [SW-1:0] prod_reg  [3];
    logic signed [W-1:0]  off2_reg;
    logic                 v2_reg;

    // stage 3: plane value
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] sum_reg;
    logic                 v3_reg;

    logic signed [SW-1:0] lim;
    logic                 ok_reg;

    always_comb begin
        logic [W-1:0]          a_v;
        logic [W-1:0]          b_v;
        logic signed [HI_W-1:0] ah;
        logic signed [HI_W-1:0] bh;
        logic signed [LO_W:0]   al;
        logic signed [LO_W:0]   bl;
        for (int a = 0; a < 3; a++) begin
            a_v = row[a*W +: W];
            b_v = point[a*W +: W];
            ah  = signed'(a_v[W-1:LO_W]);
            bh  = signed'(b_v[W-1:LO_W]);
            al  = signed'({1'b0, a_v[LO_W-1:0]});
            bl  = signed'({1'b0, b_v[LO_W-1:0]});
            pp_next[a][0] = PW'(ah * bh);
            pp_next[a][1] = PW'(ah * bl);
            pp_next[a][2] = PW'(al * bh);
            pp_next[a][3] = PW'(al * bl);
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod_next[a] = (SW'(pp_reg[a][0]) <<< (2 * LO_W))
                         + ((SW'(pp_reg[a][1]) + SW'(pp_reg[a][2])) <<< LO_W)
                         + SW'(pp_reg[a][3]);
        end
    end

    assign sum_next = prod_reg[0] + prod_reg[1] + prod_reg[2]
                    + (SW'(off2_reg) <<< FRAC_BITS);
    assign lim      = SW'(signed'(margin)) <<< FRAC_BITS;

    always_ff @(posedge aclk) begin
        pp_reg   <= pp_next;
        off1_reg <= signed'(row[3*W +: W]);
        prod_reg <= prod_next;
        off2_reg <= off1_reg;
        sum_reg  <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ok_reg <= 1'b1;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctrl.start) begin
                ok_reg <= 1'b1;
            end else if (v3_reg && (sum_reg > lim)) begin
                ok_reg <= 1'b0;
            end
        end
    end

    assign ok = ok_reg;

endmodule

// File: hw/rtl/point_in_polytope_test_top.sv
// Point-in-convex-polytope test: ring of plane cells feeding one evaluator.
// Write request: accepted in idle, then the done state hands the result off. Query
// (defined, margin >= 0): the ring rotates once, one plane per cycle, and the run
// state also drains the evaluator pipeline before done. Other queries go straight to done.
// One request in flight; the next is taken while a finished result waits.
// Reset (aresetn low, synchronous) clears the load state; plane rows are not cleared.
`timescale 1ns / 1ps

module point_in_polytope_test_top #(
    parameter int MAX_PLANES  = 32,
    parameter int COORD_WIDTH = 32,
    localparam int S_TDATA_W  = ((ppt_pkg::ROW_IDX_W + 8 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // row_index, normal_x, normal_y, normal_z, plane_offset,
    // point_x, point_y, point_z, margin (lowest bit up), zero fill
    input  logic [S_TDATA_W-1:0]         s_tdata,
    input  logic                         s_tuser,   // op
    input  logic                         s_tlast,   // last_row
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // inside_res, defined, plane_count[5:0] (lowest bit up)
    output logic [ppt_pkg::M_TDATA_W-1:0] m_tdata
);
    import ppt_pkg::*;

    localparam int W        = COORD_WIDTH;
    localparam int DRAIN    = 3;
    localparam int RUN_LAST = MAX_PLANES + DRAIN - 1;
    localparam int RCW      = $clog2(MAX_PLANES + DRAIN);

    // input field slices
    logic [ROW_IDX_W-1:0] in_idx;
    logic [4*W-1:0]       in_row;
    logic [3*W-1:0]       in_point;
    logic [W-1:0]         in_margin;
    logic                 in_zero_normal;
    logic                 in_in_range;

    assign in_idx    = s_tdata[ROW_IDX_W-1:0];
    assign in_row    = s_tdata[ROW_IDX_W +: 4*W];
    assign in_point  = s_tdata[ROW_IDX_W + 4*W +: 3*W];
    assign in_margin = s_tdata[ROW_IDX_W + 7*W +: W];
    assign in_zero_normal = (in_row[3*W-1:0] == '0);
    assign in_in_range    = (int'(in_idx) < MAX_PLANES);

    ppt_state_t           state_reg, state_next;
    logic [RCW-1:0]       run_cnt_reg, run_cnt_next;
    logic                 run_flag_reg, run_flag_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 defined_reg, defined_next;
    logic                 load_open_reg, load_open_next;
    logic                 rows_ok_reg, rows_ok_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [3*W-1:0]       point_reg;
    logic [W-1:0]         margin_reg;
    logic                 accept;
    logic                 load_out;
    logic                 eval_ok;
    logic                 shifting;
    eval_ctrl_t           ectrl;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign shifting = (state_reg == ST_RUN) && (int'(run_cnt_reg) < MAX_PLANES);

    always_comb begin
        logic ok_after;
        state_next     = state_reg;
        run_cnt_next   = run_cnt_reg;
        run_flag_next  = run_flag_reg;
        count_next     = count_reg;
        defined_next   = defined_reg;
        load_open_next = load_open_reg;
        rows_ok_next   = rows_ok_reg;
        load_out       = 1'b0;
        ok_after       = (load_open_reg ? rows_ok_reg : 1'b1)
                         && in_in_range && !in_zero_normal;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next    = ST_DONE;
                    run_flag_next = 1'b0;
                    if (s_tuser == OP_WRITE) begin
                        if (s_tlast) begin
                            load_open_next = 1'b0;
                            rows_ok_next   = ok_after;
                            defined_next   = ok_after;
                            count_next     = ok_after ? (COUNT_W'(in_idx) + COUNT_W'(1)) : '0;
                        end else begin
                            load_open_next = 1'b1;
                            rows_ok_next   = ok_after;
                            // a new load drops the current polytope
                            defined_next   = load_open_reg ? defined_reg : 1'b0;
                            count_next     = load_open_reg ? count_reg : '0;
                        end
                    end else if (defined_reg && !in_margin[W-1]) begin
                        state_next    = ST_RUN;
                        run_flag_next = 1'b1;
                        run_cnt_next  = '0;
                    end
                end
            end
            ST_RUN: begin
                if (run_cnt_reg == RCW'(RUN_LAST)) begin
                    state_next = ST_DONE;
                end else begin
                    run_cnt_next = run_cnt_reg + RCW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_cnt_reg   <= '0;
            run_flag_reg  <= 1'b0;
            count_reg     <= '0;
            defined_reg   <= 1'b0;
            load_open_reg <= 1'b0;
            rows_ok_reg   <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_cnt_reg   <= run_cnt_next;
            run_flag_reg  <= run_flag_next;
            count_reg     <= count_next;
            defined_reg   <= defined_next;
            load_open_reg <= load_open_next;
            rows_ok_reg   <= rows_ok_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == OP_QUERY)) begin
            point_reg  <= in_point;
            margin_reg <= in_margin;
        end
        if (load_out) begin
            m_tdata_reg <= {(defined_reg ? count_reg : COUNT_W'(0)),
                            defined_reg, run_flag_reg && eval_ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // plane ring: cell 0 faces the evaluator, rows move toward it
    logic [4*W-1:0] cell_row [MAX_PLANES];

    for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
        cell_ctrl_t cctrl;
        assign cctrl.load  = accept && (s_tuser == OP_WRITE) && (int'(in_idx) == i);
        assign cctrl.shift = shifting;
        ppt_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (cctrl),
            .wr_row  (in_row),
            .nbr_row (cell_row[(i + 1) % MAX_PLANES]),
            .row     (cell_row[i])
        );
    end

    assign ectrl.start = accept && (s_tuser == OP_QUERY);
    assign ectrl.issue = shifting && (int'(run_cnt_reg) < int'(count_reg));

    ppt_eval #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ectrl),
        .row     (cell_row[0]),
        .point   (point_reg),
        .margin  (margin_reg),
        .ok      (eval_ok)
    );

    a_defined_has_planes: assert property (@(posedge aclk) disable iff (!aresetn)
        defined_reg |-> (count_reg != '0) && (int'(count_reg) <= MAX_PLANES))
        else $error("defined polytope with bad plane count");

    a_open_load_undefined: assert property (@(posedge aclk) disable iff (!aresetn)
        load_open_reg |-> !defined_reg && (count_reg == '0))
        else $error("polytope defined while a load is open");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result issued outside done state");

    a_run_needs_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> defined_reg && run_flag_reg)
        else $error("evaluation running without a defined polytope");

endmodule

// File: bench/ppt_checker.sv
// Checker for the point-in-polytope test block: watches both stream channels,
// predicts each result from its own copy of the plane rows and compares in order.
// Depends on ppt_pkg for the opcode and width constants.
`timescale 1ns / 1ps

module ppt_checker #(
    parameter int MAX_PLANES  = 32,
    parameter int COORD_WIDTH = 32,
    parameter int S_TDATA_W   = 264
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ppt_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            outstanding,
    output int                            inside_count
);
    import ppt_pkg::*;

    // products and the shifted offset stay well inside this width
    localparam int SUM_W  = 2 * COORD_WIDTH + 4;
    localparam int NX_LSB = ROW_IDX_W;
    localparam int NY_LSB = NX_LSB + COORD_WIDTH;
    localparam int NZ_LSB = NY_LSB + COORD_WIDTH;
    localparam int D_LSB  = NZ_LSB + COORD_WIDTH;
    localparam int PX_LSB = D_LSB + COORD_WIDTH;
    localparam int PY_LSB = PX_LSB + COORD_WIDTH;
    localparam int PZ_LSB = PY_LSB + COORD_WIDTH;
    localparam int MG_LSB = PZ_LSB + COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic               hit;
        logic               defined;
        logic [COUNT_W-1:0] planes;
    } verdict_t;

    coord_t             row_nx  [MAX_PLANES];
    coord_t             row_ny  [MAX_PLANES];
    coord_t             row_nz  [MAX_PLANES];
    coord_t             row_ofs [MAX_PLANES];
    logic [COUNT_W-1:0] plane_total;
    logic               poly_valid;
    logic               load_active;
    logic               load_clean;
    verdict_t           awaited_verdicts [$];

    // n.p + d against the margin, all at full width, over the loaded planes
    function automatic logic point_within(input coord_t px, input coord_t py,
                                          input coord_t pz, input coord_t mg);
        logic signed [SUM_W-1:0] bound;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] ex;
        logic signed [SUM_W-1:0] ey;
        logic signed [SUM_W-1:0] ez;
        logic signed [SUM_W-1:0] ofs;
        logic                    ok;
        ok    = 1'b1;
        ex    = px;
        ey    = py;
        ez    = pz;
        bound = mg;
        bound = bound <<< FRAC_BITS;
        for (int i = 0; i < int'(plane_total); i++) begin
            ofs = row_ofs[i];
            acc = row_nx[i] * ex + row_ny[i] * ey + row_nz[i] * ez + (ofs <<< FRAC_BITS);
            if (acc > bound)
                ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic step_polytope(input logic op, input logic [S_TDATA_W-1:0] d,
                                 input logic fin);
        logic [ROW_IDX_W-1:0] idx;
        coord_t               nx;
        coord_t               ny;
        coord_t               nz;
        coord_t               mg;
        verdict_t             v;
        idx   = d[0 +: ROW_IDX_W];
        nx    = d[NX_LSB +: COORD_WIDTH];
        ny    = d[NY_LSB +: COORD_WIDTH];
        nz    = d[NZ_LSB +: COORD_WIDTH];
        mg    = d[MG_LSB +: COORD_WIDTH];
        v.hit = 1'b0;
        if (op == OP_WRITE) begin
            if (!load_active) begin
                load_active = 1'b1;
                load_clean  = 1'b1;
                poly_valid  = 1'b0;
                plane_total = '0;
            end
            if (int'(idx) < MAX_PLANES) begin
                row_nx[idx]  = nx;
                row_ny[idx]  = ny;
                row_nz[idx]  = nz;
                row_ofs[idx] = d[D_LSB +: COORD_WIDTH];
                if (nx == 0 && ny == 0 && nz == 0)
                    load_clean = 1'b0;
            end else begin
                load_clean = 1'b0;
            end
            if (fin) begin
                load_active = 1'b0;
                poly_valid  = load_clean;
                plane_total = load_clean ? COUNT_W'(idx) + 1'b1 : '0;
            end
        end else if (poly_valid && !mg[COORD_WIDTH-1]) begin
            v.hit = point_within(d[PX_LSB +: COORD_WIDTH], d[PY_LSB +: COORD_WIDTH],
                                 d[PZ_LSB +: COORD_WIDTH], mg);
        end
        v.defined = poly_valid;
        v.planes  = poly_valid ? plane_total : '0;
        awaited_verdicts.push_back(v);
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            plane_total  = '0;
            poly_valid   = 1'b0;
            load_active  = 1'b0;
            load_clean   = 1'b1;
            fail_count   = 0;
            inside_count = 0;
            awaited_verdicts.delete();
        end else begin
            // a result always belongs to an earlier request, so retire before predicting
            if (m_tvalid && m_tready) begin
                got.hit     = m_tdata[0];
                got.defined = m_tdata[1];
                got.planes  = m_tdata[2 +: COUNT_W];
                if (awaited_verdicts.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                             $time, got.hit, got.defined, got.planes);
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.hit)
                        inside_count++;
                    if (got != want) begin
                        fail_count++;
                        if (got.hit != want.hit)
                            $display("%0t: inside mismatch: expected %0d, actual %0d",
                                     $time, want.hit, got.hit);
                        if (got.defined != want.defined)
                            $display("%0t: defined mismatch: expected %0d, actual %0d",
                                     $time, want.defined, got.defined);
                        if (got.planes != want.planes)
                            $display("%0t: plane count mismatch: expected %0d, actual %0d",
                                     $time, want.planes, got.planes);
                    end
                end
            end
            if (s_tvalid && s_tready)
                step_polytope(s_tuser, s_tdata, s_tlast);
        end
        outstanding = awaited_verdicts.size();
    end

endmodule

// File: bench/point_in_polytope_test_top_tb.sv
// Testbench top for point_in_polytope_test_top: clock, reset, request and result
// traffic with random idling, watchdog and verdict. Needs ppt_pkg and ppt_checker.
`timescale 1ns / 1ps

module point_in_polytope_test_top_tb;
    import ppt_pkg::*;

    localparam int MAX_PLANES   = 32;
    localparam int COORD_WIDTH  = 32;
    localparam int S_TDATA_W    = ((ROW_IDX_W + 8 * COORD_WIDTH + 7) / 8) * 8;
    localparam int ITEM_TARGET  = 1350;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t ONE  = 32'sd65536;
    localparam coord_t MINV = 32'sh8000_0000;
    localparam coord_t MAXV = 32'sh7fff_ffff;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int inside_count;
    int sent_items   = 0;
    int writes_sent  = 0;
    int queries_sent = 0;
    int loads_closed = 0;
    int send_calm    = 0;
    int sink_calm    = 0;
    int quiet        = 0;
    int seen_prefix  = 0;
    logic row_seen [MAX_PLANES];

    point_in_polytope_test_top #(
        .MAX_PLANES  (MAX_PLANES),
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ppt_checker #(
        .MAX_PLANES  (MAX_PLANES),
        .COORD_WIDTH (COORD_WIDTH),
        .S_TDATA_W   (S_TDATA_W)
    ) verdict_watch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .inside_count (inside_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // runs of back-to-back traffic now and then, otherwise a random idle gap, possibly none
    task automatic pick_wait(inout int calm, output int cycles);
        cycles = 0;
        if (calm > 0) begin
            calm--;
        end else if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(20, 60);
        end else begin
            cycles = $urandom_range(0, 17);
        end
    endtask

    function automatic coord_t unit_coeff();
        int v;
        v = $urandom_range(0, 2 * ONE);
        return coord_t'(v - ONE);
    endfunction

    function automatic coord_t geo_coord();
        int v;
        v = $urandom_range(0, 24 * ONE);
        return coord_t'(v - 12 * ONE);
    endfunction

    function automatic coord_t geo_margin();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return coord_t'($urandom_range(0, ONE));
        else if (sel == 6)
            return '0;
        else if (sel == 7)
            return -coord_t'($urandom_range(1, ONE));
        else if (sel == 8)
            return coord_t'($urandom);
        return coord_t'($urandom_range(ONE, 16 * ONE));
    endfunction

    // mode 0: plane facing out of a region around the origin, 1: raw bits, 2: zero normal
    task automatic make_row(input int mode, output coord_t nx, output coord_t ny,
                            output coord_t nz, output coord_t ofs);
        if (mode == 1) begin
            nx  = coord_t'($urandom);
            ny  = coord_t'($urandom);
            nz  = coord_t'($urandom);
            ofs = coord_t'($urandom);
        end else if (mode == 2) begin
            nx  = '0;
            ny  = '0;
            nz  = '0;
            ofs = coord_t'($urandom);
        end else begin
            nx  = unit_coeff();
            ny  = unit_coeff();
            nz  = unit_coeff();
            ofs = -coord_t'($urandom_range(ONE, 8 * ONE));
            if (nx == 0 && ny == 0 && nz == 0)
                nx = ONE;
        end
    endtask

    task automatic send_item(input logic op, input logic [ROW_IDX_W-1:0] idx,
                             input coord_t nx, input coord_t ny, input coord_t nz,
                             input coord_t ofs, input logic fin, input coord_t px,
                             input coord_t py, input coord_t pz, input coord_t mg);
        int gap;
        pick_wait(send_calm, gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = '0;
        s_tdata[0 +: ROW_IDX_W]                    = idx;
        s_tdata[ROW_IDX_W + 0 * COORD_WIDTH +: COORD_WIDTH] = nx;
        s_tdata[ROW_IDX_W + 1 * COORD_WIDTH +: COORD_WIDTH] = ny;
        s_tdata[ROW_IDX_W + 2 * COORD_WIDTH +: COORD_WIDTH] = nz;
        s_tdata[ROW_IDX_W + 3 * COORD_WIDTH +: COORD_WIDTH] = ofs;
        s_tdata[ROW_IDX_W + 4 * COORD_WIDTH +: COORD_WIDTH] = px;
        s_tdata[ROW_IDX_W + 5 * COORD_WIDTH +: COORD_WIDTH] = py;
        s_tdata[ROW_IDX_W + 6 * COORD_WIDTH +: COORD_WIDTH] = pz;
        s_tdata[ROW_IDX_W + 7 * COORD_WIDTH +: COORD_WIDTH] = mg;
        s_tuser  = op;
        s_tlast  = fin;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_items++;
        if (op == OP_WRITE) begin
            writes_sent++;
            row_seen[idx] = 1'b1;
            while (seen_prefix < MAX_PLANES && row_seen[seen_prefix])
                seen_prefix++;
            if (fin)
                loads_closed++;
        end else begin
            queries_sent++;
        end
    endtask

    // point fields of a write and row fields of a query are don't-care: fill with noise
    task automatic write_row(input logic [ROW_IDX_W-1:0] idx, input coord_t nx,
                             input coord_t ny, input coord_t nz, input coord_t ofs,
                             input logic fin);
        send_item(OP_WRITE, idx, nx, ny, nz, ofs, fin,
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    task automatic ask_point(input coord_t px, input coord_t py, input coord_t pz,
                             input coord_t mg);
        send_item(OP_QUERY, ROW_IDX_W'($urandom_range(0, MAX_PLANES - 1)),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), logic'($urandom_range(0, 1)), px, py, pz, mg);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int     k;
        int     n;
        int     sel;
        int     idx;
        logic   paused;
        coord_t nx;
        coord_t ny;
        coord_t nz;
        coord_t ofs;

        paused   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_WRITE;
        s_tlast  = 1'b0;
        for (int i = 0; i < MAX_PLANES; i++)
            row_seen[i] = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: nothing loaded yet, then a single plane x <= 1.0
        ask_point('0, '0, '0, '0);
        write_row(0, ONE, '0, '0, -ONE, 1'b1);
        ask_point('0, '0, '0, '0);
        ask_point(2 * ONE, '0, '0, '0);
        ask_point(2 * ONE, '0, '0, ONE);          // lands exactly on the margin
        ask_point('0, '0, '0, -coord_t'(1));
        ask_point(MAXV, MAXV, MAXV, MAXV);
        // all-zero normal kills the load
        write_row(0, '0, '0, '0, ONE, 1'b1);
        ask_point('0, '0, '0, MAXV);
        // extreme rows, a query mid-load, then close at four planes
        write_row(0, MINV, MINV, MINV, MAXV, 1'b0);
        write_row(1, MAXV, MAXV, MAXV, MINV, 1'b0);
        ask_point('0, '0, '0, ONE);
        write_row(2, '0, '0, ONE, -ONE, 1'b0);
        write_row(3, '0, -ONE, '0, '0, 1'b1);
        ask_point(MINV, MINV, MINV, MAXV);
        ask_point(MAXV, MAXV, MAXV, '0);
        ask_point('0, '0, '0, MAXV);
        // top row index, then a short load that leaves row 0 stale
        write_row(31, ONE, ONE, ONE, MINV, 1'b0);
        write_row(1, '0, '0, -ONE, -ONE, 1'b1);
        ask_point('0, '0, '0, '0);
        ask_point(MINV, MAXV, '0, MAXV);
        // zero row overwritten within the same load still leaves it undefined
        write_row(4, '0, '0, '0, '0, 1'b0);
        write_row(4, ONE, '0, '0, '0, 1'b1);
        ask_point('0, '0, '0, ONE);

        while (sent_items < ITEM_TARGET) begin
            if (!paused && sent_items >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                // clean load of rows 0..k-1, then queries around it
                k = ($urandom_range(0, 6) == 0) ? $urandom_range(9, MAX_PLANES)
                                                : $urandom_range(1, 8);
                for (int r = 0; r < k; r++) begin
                    make_row(0, nx, ny, nz, ofs);
                    write_row(ROW_IDX_W'(r), nx, ny, nz, ofs, r == k - 1);
                end
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0)
                        ask_point(coord_t'($urandom), coord_t'($urandom),
                                  coord_t'($urandom), geo_margin());
                    else
                        ask_point(geo_coord(), geo_coord(), geo_coord(), geo_margin());
                end
            end else if (sel < 85) begin
                // scattered rows, zero normals, queries mid-load, stale rows kept
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0)
                        ask_point(geo_coord(), geo_coord(), geo_coord(), geo_margin());
                    k = $urandom_range(0, 9);
                    make_row(k < 2 ? 2 : (k < 5 ? 1 : 0), nx, ny, nz, ofs);
                    write_row(ROW_IDX_W'($urandom_range(0, MAX_PLANES - 1)),
                              nx, ny, nz, ofs, 1'b0);
                end
                // only close where every row below has been written at some point
                idx = $urandom_range(0, seen_prefix < MAX_PLANES ? seen_prefix
                                                                 : MAX_PLANES - 1);
                k   = $urandom_range(0, 9);
                make_row(k == 0 ? 2 : (k < 3 ? 1 : 0), nx, ny, nz, ofs);
                write_row(ROW_IDX_W'(idx), nx, ny, nz, ofs, 1'b1);
                n = $urandom_range(1, 4);
                repeat (n)
                    ask_point(geo_coord(), geo_coord(), geo_coord(), geo_margin());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n)
                    ask_point(coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom));
            end
        end

        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        $display("Ran %0d requests: %0d row writes closing %0d loads, %0d point queries.",
                 sent_items, writes_sent, loads_closed, queries_sent);
        $display("%0d queries came back inside; %0d result mismatches.",
                 inside_count, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            pick_wait(sink_calm, stall);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // give up when neither channel moves for far longer than any legal stall
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
